// ===== rtl/core/spi_master_controller_registers_top_assert.svh =====
// Assertion macros shared by the SPI master register block.
// The including module must provide clk_i and rst_ni.
`ifndef SPI_MASTER_CONTROLLER_REGISTERS_TOP_ASSERT_SVH
`define SPI_MASTER_CONTROLLER_REGISTERS_TOP_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define SPIMC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define SPIMC_ASSERT_NEXT(name, cond, nxt, msg) \
  `SPIMC_ASSERT(name, (cond) |=> (nxt), msg)

`endif

// ===== rtl/core/spimc_pkg.sv =====
// Package for the SPI master register block: register map, flag bits,
// item and result types and small helper functions. No dependencies.
`timescale 1ns / 1ps

package spimc_pkg;

  localparam int FORMAT_COUNT = 4;
  localparam int FMT_IDX_W    = (FORMAT_COUNT > 1) ? $clog2(FORMAT_COUNT) : 1;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  // Register word offsets.
  localparam logic [6:0] REG_ENABLE   = 7'd0;
  localparam logic [6:0] REG_GCTRL    = 7'd1;
  localparam logic [6:0] REG_INT_EN   = 7'd2;
  localparam logic [6:0] REG_INT_LVL  = 7'd3;
  localparam logic [6:0] REG_FLAGS    = 7'd4;
  localparam logic [6:0] REG_PIN_CTRL = 7'd5;
  localparam logic [6:0] REG_DATA0    = 7'd14;
  localparam logic [6:0] REG_DATA1    = 7'd15;
  localparam logic [6:0] REG_BUF      = 7'd16;
  localparam logic [6:0] REG_BUF_EMU  = 7'd17;
  localparam logic [6:0] REG_CS_DELAY = 7'd18;
  localparam logic [6:0] REG_CS_DEF   = 7'd19;
  localparam logic [6:0] REG_FMT0     = 7'd20;
  localparam logic [6:0] REG_FMT_LAST = 7'(20 + FORMAT_COUNT - 1);
  localparam logic [6:0] REG_VEC0     = 7'd24;
  localparam logic [6:0] REG_VEC1     = 7'd25;

  // Bit positions.
  localparam int GC_MASTER_BIT   = 0;
  localparam int GC_LOOPBACK_BIT = 16;
  localparam int GC_ENABLE_BIT   = 24;
  localparam int IE_DMA_BIT      = 16;
  localparam int FL_OVRN_BIT     = 6;
  localparam int FL_RX_BIT       = 8;
  localparam int FL_TX_BIT       = 9;
  localparam int DC_WDEL_BIT     = 10;
  localparam int DC_HOLD_BIT     = 12;

  localparam logic [9:0] FL_ALL = 10'h340;

  // Interrupt vector codes.
  localparam logic [31:0] VEC_OVRN = 32'h13 << 1;
  localparam logic [31:0] VEC_RX   = 32'h12 << 1;
  localparam logic [31:0] VEC_TX   = 32'h14 << 1;
  localparam logic [31:0] VEC_NONE = 32'h0;

  typedef logic [FORMAT_COUNT-1:0][31:0] fmt_array_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [6:0]  reg_index;
    logic [31:0] write_data;
    logic [3:0]  byte_enable;
    logic [15:0] peer_rx_word;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_line0;
    logic        irq_line1;
    logic        tx_dma_request;
    logic        rx_dma_request;
    logic        xfer_valid;
    logic [15:0] xfer_tx_word;
    logic [4:0]  xfer_bits;
    logic [7:0]  xfer_chip_select;
    logic        xfer_cs_hold;
  } result_t;

  function automatic logic [31:0] byte_mask(input logic [3:0] be);
    return {{8{be[3]}}, {8{be[2]}}, {8{be[1]}}, {8{be[0]}}};
  endfunction

  // Format selected by bits 9:8 of the data control half; zero if absent.
  function automatic logic [31:0] cur_fmt(input fmt_array_t fmts, input logic [15:0] dc);
    logic [1:0] sel;
    sel = dc[9:8];
    if (32'(sel) < FORMAT_COUNT) begin
      return fmts[sel[FMT_IDX_W-1:0]];
    end
    return '0;
  endfunction

  function automatic logic [31:0] int_vector(input logic [9:0]  flags,
                                             input logic [31:0] ie,
                                             input logic [31:0] lvl,
                                             input logic        line);
    logic [9:0] pend;
    pend = flags & ie[9:0] & (line ? lvl[9:0] : ~lvl[9:0]);
    if (pend[FL_OVRN_BIT]) begin
      return VEC_OVRN;
    end
    if (pend[FL_RX_BIT]) begin
      return VEC_RX;
    end
    if (pend[FL_TX_BIT]) begin
      return VEC_TX;
    end
    return VEC_NONE;
  endfunction

endpackage

// ===== rtl/core/spi_master_controller_registers_top.sv =====
// SPI master register block, top level: input register, state update, result register.
// The input register holds the accepted item; the result register holds its result.
// Throughput: one item per cycle unless stalled; the single pass through spimc_core sets it.
// The input register is held while the result register is stalled and full.
// Reset (rst_ni low, asynchronous) clears all but item and result data; rx_empty resets to 1.
// Depends on spimc_pkg and spimc_core.
`timescale 1ns / 1ps

module spi_master_controller_registers_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [6:0]  reg_index_i,
  input  logic [31:0] write_data_i,
  input  logic [3:0]  byte_enable_i,
  input  logic [15:0] peer_rx_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_data_o,
  output logic        irq_line0_o,
  output logic        irq_line1_o,
  output logic        tx_dma_request_o,
  output logic        rx_dma_request_o,
  output logic        xfer_valid_o,
  output logic [15:0] xfer_tx_word_o,
  output logic [4:0]  xfer_bits_o,
  output logic [7:0]  xfer_chip_select_o,
  output logic        xfer_cs_hold_o
);
  import spimc_pkg::*;

  logic    in_valid_q;
  item_t   item_q;
  logic    out_valid_q;
  result_t result_q;
  result_t result_d;
  logic    fire;
  logic    in_accept;

  // The held item is processed when the result register can take its result.
  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= '{cmd: cmd_i, reg_index: reg_index_i, write_data: write_data_i,
                  byte_enable: byte_enable_i, peer_rx_word: peer_rx_word_i};
    end
  end

  spimc_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .item_i  (item_q),
    .result_o(result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign read_data_o        = result_q.read_data;
  assign irq_line0_o        = result_q.irq_line0;
  assign irq_line1_o        = result_q.irq_line1;
  assign tx_dma_request_o   = result_q.tx_dma_request;
  assign rx_dma_request_o   = result_q.rx_dma_request;
  assign xfer_valid_o       = result_q.xfer_valid;
  assign xfer_tx_word_o     = result_q.xfer_tx_word;
  assign xfer_bits_o        = result_q.xfer_bits;
  assign xfer_chip_select_o = result_q.xfer_chip_select;
  assign xfer_cs_hold_o     = result_q.xfer_cs_hold;

endmodule

// ===== rtl/core/spimc_word_ticks.sv =====
// Countdown length for one word: bits times prescale plus chip-select and
// word delays. No dependencies.
`timescale 1ns / 1ps

module spimc_word_ticks (
  input  logic [31:0] fmt_i,
  input  logic [31:0] cs_delay_i,
  input  logic        hold_prev_i,
  input  logic        word_delay_i,
  output logic [13:0] ticks_o
);

  logic [8:0]  prescale;
  logic [13:0] prod;
  logic [13:0] cs_add;
  logic [13:0] wd_add;
  logic [13:0] sum;

  assign prescale = 9'(fmt_i[15:8]) + 9'd1;
  assign prod     = 14'(fmt_i[4:0]) * 14'(prescale);
  assign cs_add   = hold_prev_i ? 14'd0
                    : 14'(cs_delay_i[31:24]) + 14'(cs_delay_i[23:16]) + 14'd3;
  assign wd_add   = word_delay_i ? 14'(fmt_i[29:24]) + 14'd2 : 14'd0;
  assign sum      = prod + cs_add + wd_add;

  // A word never takes less than one tick.
  assign ticks_o  = (sum == 14'd0) ? 14'd1 : sum;

endmodule

// ===== rtl/core/spimc_core.sv =====
// Register state and single-pass update of the SPI master register block.
// Depends on spimc_pkg, spimc_word_ticks and the assertion macro header.
`timescale 1ns / 1ps
`include "spi_master_controller_registers_top_assert.svh"

module spimc_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  spimc_pkg::item_t item_i,
  output spimc_pkg::result_t result_o
);
  import spimc_pkg::*;

  logic        module_enable_q, module_enable_d;
  logic [31:0] gctrl_q, gctrl_d;
  logic [31:0] int_en_q, int_en_d;
  logic [31:0] int_lvl_q, int_lvl_d;
  logic [9:0]  int_flags_q, int_flags_d;
  logic [31:0] pin_ctrl_q, pin_ctrl_d;
  logic [31:0] cs_delay_q, cs_delay_d;
  logic [31:0] cs_def_q, cs_def_d;
  fmt_array_t  fmts_q, fmts_d;
  logic [15:0] data_ctrl_q, data_ctrl_d;
  logic [15:0] tx_word_q, tx_word_d;
  logic [15:0] rx_word_q, rx_word_d;
  logic        rx_overrun_q, rx_overrun_d;
  logic        rx_empty_q, rx_empty_d;
  logic        tx_full_q, tx_full_d;
  logic        hold_prev_q, hold_prev_d;
  logic        busy_q, busy_d;
  logic [13:0] ticks_left_q, ticks_left_d;

  logic [31:0] mask;
  logic [31:0] data_v;
  logic [15:0] start_dc;
  logic [31:0] start_fmt;
  logic [31:0] fin_fmt;
  logic [13:0] word_ticks;
  logic [13:0] tick_dec;
  logic [6:0]  fmt_off;
  logic [FMT_IDX_W-1:0] fmt_sel;
  logic        do_start;
  logic        do_finish;
  logic        dma;
  logic [9:0]  pend;
  logic        tick_busy;
  logic        last_tick;
  result_t     res;

  assign mask     = byte_mask(item_i.byte_enable);
  assign data_v   = ({data_ctrl_q, tx_word_q} & ~mask) | (item_i.write_data & mask);
  // A data1 write updates the control half before the countdown is sized.
  assign start_dc = (item_i.reg_index == REG_DATA1) ? data_v[31:16] : data_ctrl_q;
  assign start_fmt = cur_fmt(fmts_q, start_dc);
  assign fin_fmt  = cur_fmt(fmts_q, data_ctrl_q);
  assign tick_dec = (ticks_left_q != 14'd0) ? ticks_left_q - 14'd1 : 14'd0;
  assign fmt_off  = item_i.reg_index - REG_FMT0;
  assign fmt_sel  = fmt_off[FMT_IDX_W-1:0];

  spimc_word_ticks u_word_ticks (
    .fmt_i       (start_fmt),
    .cs_delay_i  (cs_delay_q),
    .hold_prev_i (hold_prev_q),
    .word_delay_i(start_dc[DC_WDEL_BIT]),
    .ticks_o     (word_ticks)
  );

  always_comb begin
    module_enable_d = module_enable_q;
    gctrl_d         = gctrl_q;
    int_en_d        = int_en_q;
    int_lvl_d       = int_lvl_q;
    int_flags_d     = int_flags_q;
    pin_ctrl_d      = pin_ctrl_q;
    cs_delay_d      = cs_delay_q;
    cs_def_d        = cs_def_q;
    fmts_d          = fmts_q;
    data_ctrl_d     = data_ctrl_q;
    tx_word_d       = tx_word_q;
    rx_word_d       = rx_word_q;
    rx_overrun_d    = rx_overrun_q;
    rx_empty_d      = rx_empty_q;
    tx_full_d       = tx_full_q;
    hold_prev_d     = hold_prev_q;
    busy_d          = busy_q;
    ticks_left_d    = ticks_left_q;
    res             = '0;
    do_start        = 1'b0;
    do_finish       = 1'b0;

    case (item_i.cmd)
      CMD_READ: begin
        if (item_i.reg_index inside {[REG_FMT0:REG_FMT_LAST]}) begin
          res.read_data = fmts_q[fmt_sel];
        end else begin
          case (item_i.reg_index)
            REG_ENABLE:   res.read_data = {31'd0, module_enable_q};
            REG_GCTRL:    res.read_data = gctrl_q;
            REG_INT_EN:   res.read_data = int_en_q;
            REG_INT_LVL:  res.read_data = int_lvl_q;
            REG_FLAGS:    res.read_data = {22'd0, int_flags_q};
            REG_PIN_CTRL: res.read_data = pin_ctrl_q;
            REG_DATA0:    res.read_data = {16'd0, tx_word_q};
            REG_DATA1:    res.read_data = {data_ctrl_q, tx_word_q};
            REG_BUF: begin
              res.read_data = {rx_empty_q, rx_overrun_q, tx_full_q, 13'd0, rx_word_q};
              // Reading the buffer consumes the received word.
              rx_empty_d   = 1'b1;
              rx_overrun_d = 1'b0;
              int_flags_d[FL_RX_BIT]   = 1'b0;
              int_flags_d[FL_OVRN_BIT] = 1'b0;
            end
            REG_BUF_EMU:  res.read_data = {rx_empty_q, rx_overrun_q, tx_full_q, 13'd0,
                                           rx_word_q};
            REG_CS_DELAY: res.read_data = cs_delay_q;
            REG_CS_DEF:   res.read_data = cs_def_q;
            REG_VEC0:     res.read_data = int_vector(int_flags_q, int_en_q, int_lvl_q, 1'b0);
            REG_VEC1:     res.read_data = int_vector(int_flags_q, int_en_q, int_lvl_q, 1'b1);
            default:      res.read_data = '0;
          endcase
        end
      end
      CMD_WRITE: begin
        if (item_i.byte_enable != 4'd0) begin
          if (item_i.reg_index inside {[REG_FMT0:REG_FMT_LAST]}) begin
            fmts_d[fmt_sel] = (fmts_q[fmt_sel] & ~mask) | (item_i.write_data & mask);
          end else begin
            case (item_i.reg_index)
              REG_ENABLE: begin
                module_enable_d = mask[0] ? item_i.write_data[0] : module_enable_q;
                // Putting the module into reset clears all but the formats.
                if (!module_enable_d) begin
                  gctrl_d      = '0;
                  int_en_d     = '0;
                  int_lvl_d    = '0;
                  int_flags_d  = '0;
                  pin_ctrl_d   = '0;
                  cs_delay_d   = '0;
                  cs_def_d     = '0;
                  data_ctrl_d  = '0;
                  tx_word_d    = '0;
                  rx_word_d    = '0;
                  rx_overrun_d = 1'b0;
                  rx_empty_d   = 1'b1;
                  tx_full_d    = 1'b0;
                  hold_prev_d  = 1'b0;
                  busy_d       = 1'b0;
                  ticks_left_d = '0;
                end
              end
              REG_GCTRL:    gctrl_d    = (gctrl_q & ~mask) | (item_i.write_data & mask);
              REG_INT_EN:   int_en_d   = (int_en_q & ~mask) | (item_i.write_data & mask);
              REG_INT_LVL:  int_lvl_d  = (int_lvl_q & ~mask) | (item_i.write_data & mask);
              REG_FLAGS:    int_flags_d = int_flags_q & ~(item_i.write_data[9:0] & mask[9:0]);
              REG_PIN_CTRL: pin_ctrl_d = (pin_ctrl_q & ~mask) | (item_i.write_data & mask);
              REG_DATA0:    do_start   = 1'b1;
              REG_DATA1: begin
                data_ctrl_d = data_v[31:16];
                do_start    = |item_i.byte_enable[1:0];
              end
              REG_CS_DELAY: cs_delay_d = (cs_delay_q & ~mask) | (item_i.write_data & mask);
              REG_CS_DEF:   cs_def_d   = (cs_def_q & ~mask) | (item_i.write_data & mask);
              default: ;
            endcase
          end
        end
      end
      CMD_TICK: begin
        if (busy_q) begin
          if (tick_dec == 14'd0) begin
            do_finish = 1'b1;
          end else begin
            ticks_left_d = tick_dec;
          end
        end
      end
      default: ;
    endcase

    if (do_start && module_enable_q) begin
      tx_word_d              = data_v[15:0];
      tx_full_d              = 1'b1;
      int_flags_d[FL_TX_BIT] = 1'b0;
      if (gctrl_q[GC_ENABLE_BIT] && gctrl_q[GC_MASTER_BIT] && !busy_q) begin
        busy_d       = 1'b1;
        ticks_left_d = word_ticks;
      end
    end

    if (do_finish) begin
      if (gctrl_q[GC_LOOPBACK_BIT]) begin
        rx_word_d = tx_word_q;
      end else begin
        rx_word_d            = item_i.peer_rx_word;
        res.xfer_valid       = 1'b1;
        res.xfer_tx_word     = tx_word_q;
        res.xfer_bits        = fin_fmt[4:0];
        res.xfer_chip_select = data_ctrl_q[7:0];
        res.xfer_cs_hold     = data_ctrl_q[DC_HOLD_BIT];
      end
      if (!rx_empty_q) begin
        rx_overrun_d             = 1'b1;
        int_flags_d[FL_OVRN_BIT] = 1'b1;
      end
      rx_empty_d             = 1'b0;
      int_flags_d[FL_RX_BIT] = 1'b1;
      int_flags_d[FL_TX_BIT] = 1'b1;
      tx_full_d              = 1'b0;
      hold_prev_d            = data_ctrl_q[DC_HOLD_BIT];
      busy_d                 = 1'b0;
      ticks_left_d           = '0;
    end

    pend               = int_flags_d & int_en_d[9:0] & FL_ALL;
    dma                = int_en_d[IE_DMA_BIT] && gctrl_d[GC_ENABLE_BIT];
    res.irq_line0      = |(pend & ~int_lvl_d[9:0]);
    res.irq_line1      = |(pend & int_lvl_d[9:0]);
    res.tx_dma_request = dma && !tx_full_d;
    res.rx_dma_request = dma && !rx_empty_d;
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      module_enable_q <= 1'b0;
      gctrl_q         <= '0;
      int_en_q        <= '0;
      int_lvl_q       <= '0;
      int_flags_q     <= '0;
      pin_ctrl_q      <= '0;
      cs_delay_q      <= '0;
      cs_def_q        <= '0;
      fmts_q          <= '0;
      data_ctrl_q     <= '0;
      tx_word_q       <= '0;
      rx_word_q       <= '0;
      rx_overrun_q    <= 1'b0;
      rx_empty_q      <= 1'b1;
      tx_full_q       <= 1'b0;
      hold_prev_q     <= 1'b0;
      busy_q          <= 1'b0;
      ticks_left_q    <= '0;
    end else if (fire_i) begin
      module_enable_q <= module_enable_d;
      gctrl_q         <= gctrl_d;
      int_en_q        <= int_en_d;
      int_lvl_q       <= int_lvl_d;
      int_flags_q     <= int_flags_d;
      pin_ctrl_q      <= pin_ctrl_d;
      cs_delay_q      <= cs_delay_d;
      cs_def_q        <= cs_def_d;
      fmts_q          <= fmts_d;
      data_ctrl_q     <= data_ctrl_d;
      tx_word_q       <= tx_word_d;
      rx_word_q       <= rx_word_d;
      rx_overrun_q    <= rx_overrun_d;
      rx_empty_q      <= rx_empty_d;
      tx_full_q       <= tx_full_d;
      hold_prev_q     <= hold_prev_d;
      busy_q          <= busy_d;
      ticks_left_q    <= ticks_left_d;
    end
  end

  assign tick_busy = busy_q && (item_i.cmd == CMD_TICK);
  assign last_tick = fire_i && tick_busy && (ticks_left_q < 14'd2);

  `SPIMC_ASSERT(a_idle_count_zero, !busy_q |-> (ticks_left_q == 14'd0), "count left while idle")
  `SPIMC_ASSERT(a_empty_no_overrun, rx_empty_q |-> !rx_overrun_q, "overrun with empty buffer")
  `SPIMC_ASSERT(a_busy_enabled, busy_q |-> module_enable_q, "busy while module in reset")
  `SPIMC_ASSERT_NEXT(a_last_tick_ends, last_tick, !busy_q, "exchange did not end on its last tick")
  `SPIMC_ASSERT(a_xfer_needs_tick, result_o.xfer_valid |-> tick_busy, "exchange without a tick")

endmodule

// ===== verif/tb_spi_master_controller_registers_top.sv =====
// Testbench for the SPI master register block: register accesses and module clock ticks are
// checked against a mirror of the register state that predicts one result for every item.
// Depends on spimc_pkg and spi_master_controller_registers_top.
`timescale 1ns / 1ps

module tb_spi_master_controller_registers_top;
  import spimc_pkg::*;

  localparam int ITEM_GOAL = 1550;
  localparam logic [6:0] STATUS_REGS [6] = '{REG_BUF_EMU, REG_VEC0, REG_VEC1, REG_FLAGS,
                                              REG_DATA1, REG_BUF};

  // Mirror of the register block; every accepted item queues the result it must produce.
  class spimc_mirror;
    bit          module_on;
    logic [31:0] gctrl, int_en, int_lvl, pin_ctrl, cs_dly, cs_dflt;
    logic [9:0]  flags;
    logic [31:0] formats [FORMAT_COUNT];
    logic [15:0] dctrl, tx_buf, rx_buf;
    bit          rx_ovr, rx_none, tx_held, hold_last, busy;
    int unsigned ticks_to_go;
    result_t     replies_due [$];
    int unsigned mismatches;

    function new();
      wipe();
      foreach (formats[i]) formats[i] = '0;
      mismatches = 0;
    endfunction

    // A module reset clears everything but the data formats.
    function void wipe();
      module_on = 0; gctrl = '0; int_en = '0; int_lvl = '0; pin_ctrl = '0;
      cs_dly = '0; cs_dflt = '0; flags = '0; dctrl = '0; tx_buf = '0; rx_buf = '0;
      rx_ovr = 0; rx_none = 1; tx_held = 0; hold_last = 0; busy = 0; ticks_to_go = 0;
    endfunction

    function logic [31:0] lanes(logic [31:0] old, logic [31:0] val, logic [3:0] be);
      logic [31:0] m;
      for (int b = 0; b < 4; b++) m[8*b +: 8] = {8{be[b]}};
      return (old & ~m) | (val & m);
    endfunction

    function logic [31:0] selected_format();
      logic [1:0] sel;
      sel = dctrl[9:8];
      if (int'(sel) < FORMAT_COUNT) return formats[sel];
      return '0;
    endfunction

    function int unsigned countdown_length();
      logic [31:0] f;
      int unsigned n;
      f = selected_format();
      n = 32'(f[4:0]) * (32'(f[15:8]) + 1);
      if (!hold_last) n += 32'(cs_dly[31:24]) + 32'(cs_dly[23:16]) + 3;
      if (dctrl[DC_WDEL_BIT]) n += 32'(f[29:24]) + 2;
      return (n == 0) ? 1 : n;
    endfunction

    function void load_word(logic [15:0] w);
      if (!module_on) return;
      tx_buf = w;
      tx_held = 1;
      flags[FL_TX_BIT] = 0;
      if (gctrl[GC_ENABLE_BIT] && gctrl[GC_MASTER_BIT] && !busy) begin
        busy = 1;
        ticks_to_go = countdown_length();
      end
    endfunction

    function void complete_word(input logic [15:0] peer, inout result_t r);
      logic [31:0] f;
      logic [15:0] got;
      f = selected_format();
      if (gctrl[GC_LOOPBACK_BIT]) begin
        got = tx_buf;
      end else begin
        got = peer;
        r.xfer_valid = 1'b1;
        r.xfer_tx_word = tx_buf;
        r.xfer_bits = f[4:0];
        r.xfer_chip_select = dctrl[7:0];
        r.xfer_cs_hold = dctrl[DC_HOLD_BIT];
      end
      if (!rx_none) begin
        rx_ovr = 1;
        flags[FL_OVRN_BIT] = 1;
      end
      rx_buf = got;
      rx_none = 0;
      flags[FL_RX_BIT] = 1;
      flags[FL_TX_BIT] = 1;
      tx_held = 0;
      hold_last = dctrl[DC_HOLD_BIT];
      busy = 0;
      ticks_to_go = 0;
    endfunction

    function logic [31:0] vector_code(bit line);
      logic [9:0] p;
      p = flags & int_en[9:0] & (line ? int_lvl[9:0] : ~int_lvl[9:0]);
      if (p[FL_OVRN_BIT]) return VEC_OVRN;
      if (p[FL_RX_BIT]) return VEC_RX;
      if (p[FL_TX_BIT]) return VEC_TX;
      return VEC_NONE;
    endfunction

    function logic [31:0] read_reg(logic [6:0] idx);
      logic [31:0] v;
      if (idx >= REG_FMT0 && idx <= REG_FMT_LAST) return formats[idx - REG_FMT0];
      case (idx)
        REG_ENABLE:   return {31'b0, module_on};
        REG_GCTRL:    return gctrl;
        REG_INT_EN:   return int_en;
        REG_INT_LVL:  return int_lvl;
        REG_FLAGS:    return {22'b0, flags};
        REG_PIN_CTRL: return pin_ctrl;
        REG_DATA0:    return {16'b0, tx_buf};
        REG_DATA1:    return {dctrl, tx_buf};
        REG_BUF, REG_BUF_EMU: begin
          v = {rx_none, rx_ovr, tx_held, 13'b0, rx_buf};
          // Only the real buffer address consumes the received word.
          if (idx == REG_BUF) begin
            rx_none = 1;
            rx_ovr = 0;
            flags[FL_RX_BIT] = 0;
            flags[FL_OVRN_BIT] = 0;
          end
          return v;
        end
        REG_CS_DELAY: return cs_dly;
        REG_CS_DEF:   return cs_dflt;
        REG_VEC0:     return vector_code(1'b0);
        REG_VEC1:     return vector_code(1'b1);
        default:      return '0;
      endcase
    endfunction

    function void write_reg(logic [6:0] idx, logic [31:0] val, logic [3:0] be);
      logic [31:0] v;
      if (be == 4'h0) return;
      if (idx >= REG_FMT0 && idx <= REG_FMT_LAST) begin
        formats[idx - REG_FMT0] = lanes(formats[idx - REG_FMT0], val, be);
        return;
      end
      case (idx)
        REG_ENABLE: begin
          v = lanes({31'b0, module_on}, val, be);
          if (!v[0]) wipe();
          else module_on = 1;
        end
        REG_GCTRL:    gctrl = lanes(gctrl, val, be);
        REG_INT_EN:   int_en = lanes(int_en, val, be);
        REG_INT_LVL:  int_lvl = lanes(int_lvl, val, be);
        REG_FLAGS: begin
          v = lanes('0, val, be);
          flags &= ~v[9:0];
        end
        REG_PIN_CTRL: pin_ctrl = lanes(pin_ctrl, val, be);
        REG_DATA0: begin
          v = lanes({16'b0, tx_buf}, val, be);
          load_word(v[15:0]);
        end
        REG_DATA1: begin
          v = lanes({dctrl, tx_buf}, val, be);
          dctrl = v[31:16];
          if (be[0] || be[1]) load_word(v[15:0]);
        end
        REG_CS_DELAY: cs_dly = lanes(cs_dly, val, be);
        REG_CS_DEF:   cs_dflt = lanes(cs_dflt, val, be);
        default: ;
      endcase
    endfunction

    function void note_item(item_t it);
      result_t r;
      logic [9:0] pend;
      bit dma;
      r = '0;
      case (it.cmd)
        CMD_READ:  r.read_data = read_reg(it.reg_index);
        CMD_WRITE: write_reg(it.reg_index, it.write_data, it.byte_enable);
        CMD_TICK: begin
          if (busy) begin
            if (ticks_to_go > 0) ticks_to_go--;
            if (ticks_to_go == 0) complete_word(it.peer_rx_word, r);
          end
        end
        default: ;
      endcase
      pend = flags & int_en[9:0] & FL_ALL;
      dma = int_en[IE_DMA_BIT] && gctrl[GC_ENABLE_BIT];
      r.irq_line0 = |(pend & ~int_lvl[9:0]);
      r.irq_line1 = |(pend & int_lvl[9:0]);
      r.tx_dma_request = dma && !tx_held;
      r.rx_dma_request = dma && !rx_none;
      replies_due.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (replies_due.size() == 0) begin
        $display("%0t: result with no item waiting, expected none, actual %p", $time, got);
        mismatches++;
        return;
      end
      want = replies_due.pop_front();
      check_field("read_data", want.read_data, got.read_data);
      check_field("irq_line0", want.irq_line0, got.irq_line0);
      check_field("irq_line1", want.irq_line1, got.irq_line1);
      check_field("tx_dma_request", want.tx_dma_request, got.tx_dma_request);
      check_field("rx_dma_request", want.rx_dma_request, got.rx_dma_request);
      check_field("xfer_valid", want.xfer_valid, got.xfer_valid);
      check_field("xfer_tx_word", want.xfer_tx_word, got.xfer_tx_word);
      check_field("xfer_bits", want.xfer_bits, got.xfer_bits);
      check_field("xfer_chip_select", want.xfer_chip_select, got.xfer_chip_select);
      check_field("xfer_cs_hold", want.xfer_cs_hold, got.xfer_cs_hold);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd_i = '0;
  logic [6:0]  reg_index_i = '0;
  logic [31:0] write_data_i = '0;
  logic [3:0]  byte_enable_i = '0;
  logic [15:0] peer_rx_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] read_data_o;
  logic        irq_line0_o, irq_line1_o, tx_dma_request_o, rx_dma_request_o;
  logic        xfer_valid_o;
  logic [15:0] xfer_tx_word_o;
  logic [4:0]  xfer_bits_o;
  logic [7:0]  xfer_chip_select_o;
  logic        xfer_cs_hold_o;

  spimc_mirror mirror = new();
  int          sender_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          items_done = 0;

  spi_master_controller_registers_top DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(5_000_000);
    $display("TEST FAILED");
    $finish;
  end

  // Result side: outputs are sampled at the edge, before the block updates them.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      mirror.check_result('{read_data: read_data_o, irq_line0: irq_line0_o,
                            irq_line1: irq_line1_o, tx_dma_request: tx_dma_request_o,
                            rx_dma_request: rx_dma_request_o, xfer_valid: xfer_valid_o,
                            xfer_tx_word: xfer_tx_word_o, xfer_bits: xfer_bits_o,
                            xfer_chip_select: xfer_chip_select_o,
                            xfer_cs_hold: xfer_cs_hold_o});
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Offers one item and returns at the edge where it is accepted.
  task automatic access(input logic [1:0] c, input logic [6:0] idx,
                        input logic [31:0] data, input logic [3:0] be);
    item_t it;
    bit counts;
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    it = '{cmd: c, reg_index: idx, write_data: data, byte_enable: be,
           peer_rx_word: 16'($urandom)};
    in_valid_i <= 1'b1;
    cmd_i <= it.cmd;
    reg_index_i <= it.reg_index;
    write_data_i <= it.write_data;
    byte_enable_i <= it.byte_enable;
    peer_rx_word_i <= it.peer_rx_word;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    // Idle ticks, empty writes and the undefined command leave the block untouched.
    counts = (c == CMD_READ) || (c == CMD_WRITE && be != 4'h0) ||
             (c == CMD_TICK && mirror.busy);
    mirror.note_item(it);
    if (counts) items_done++;
  endtask

  task automatic reg_read(input logic [6:0] idx);
    access(CMD_READ, idx, $urandom, 4'($urandom_range(15)));
  endtask

  task automatic reg_write(input logic [6:0] idx, input logic [31:0] val);
    access(CMD_WRITE, idx, val, 4'hF);
  endtask

  task automatic tick();
    access(CMD_TICK, 7'($urandom_range(127)), $urandom, 4'($urandom_range(15)));
  endtask

  task automatic tick_out_word();
    while (mirror.busy) tick();
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (mirror.replies_due.size() != 0);
  endtask

  task automatic noise_item();
    access(2'($urandom_range(3)),
           7'(($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(31)),
           $urandom, 4'($urandom_range(15)));
  endtask

  // Set up a format and send one word, with status reads and the odd reset woven in.
  task automatic word_exchange(input bit longest);
    logic [31:0] gc, fmt, cd;
    logic [15:0] dc;
    logic [1:0]  slot;
    if (longest) reg_write(REG_ENABLE, 32'h0);
    if (longest || !mirror.module_on || $urandom_range(19) == 0)
      reg_write(REG_ENABLE, $urandom | 32'h1);
    if (longest || !mirror.gctrl[GC_ENABLE_BIT] || !mirror.gctrl[GC_MASTER_BIT] ||
        $urandom_range(3) == 0) begin
      gc = $urandom;
      gc[GC_MASTER_BIT] = 1'b1;
      gc[GC_ENABLE_BIT] = 1'b1;
      gc[GC_LOOPBACK_BIT] = !longest && $urandom_range(3) == 0;
      reg_write(REG_GCTRL, gc);
    end
    if ($urandom_range(2) == 0) begin
      reg_write(REG_INT_EN, $urandom);
      reg_write(REG_INT_LVL, $urandom);
    end
    slot = 2'($urandom_range(FORMAT_COUNT - 1));
    fmt = $urandom;
    fmt[4:0] = 5'(($urandom_range(7) == 0) ? $urandom_range(31) : $urandom_range(6));
    fmt[15:8] = 8'($urandom_range(2));
    fmt[29:24] = 6'($urandom_range(3));
    // Widest character and largest word delay, with a short prescale.
    if (longest) fmt = 32'hFFFF_01FF;
    reg_write(REG_FMT0 + 7'(slot), fmt);
    if (longest || $urandom_range(2) == 0) begin
      cd = $urandom;
      cd[31:24] = 8'($urandom_range(3));
      cd[23:16] = 8'($urandom_range(3));
      reg_write(REG_CS_DELAY, longest ? '1 : cd);
    end
    dc = 16'($urandom);
    dc[9:8] = slot;
    if (longest) dc[DC_WDEL_BIT] = 1'b1;
    if ($urandom_range(1) == 0) begin
      access(CMD_WRITE, REG_DATA1, {dc, 16'($urandom)}, 4'hC | 4'($urandom_range(1, 3)));
    end else begin
      access(CMD_WRITE, REG_DATA1, {dc, 16'($urandom)}, 4'hC);
      access(CMD_WRITE, REG_DATA0, $urandom, 4'($urandom_range(1, 15)));
    end
    if ($urandom_range(3) == 0) reg_write(REG_DATA0, $urandom);
    while (mirror.busy) begin
      if ($urandom_range(9) == 0) reg_read(STATUS_REGS[$urandom_range(5)]);
      else if (!longest && $urandom_range(59) == 0) reg_write(REG_ENABLE, 32'h0);
      else tick();
    end
    // Leaving the word unread now and then lets the next one overrun.
    if ($urandom_range(2) != 0) reg_read(REG_BUF);
    if ($urandom_range(1) == 0) begin
      reg_read(REG_VEC0);
      reg_read(REG_VEC1);
    end
    if ($urandom_range(3) == 0) reg_write(REG_FLAGS, $urandom);
  endtask

  initial begin
    int goal;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: reset values, edge cases of the register map, one plain word
    // with an overrun behind it, one loopback word and a module reset.
    reg_read(REG_BUF_EMU);
    access(CMD_WRITE, REG_FMT0, '1, 4'h0);
    reg_write(REG_FMT_LAST, 32'hFFFF_FFFF);
    access(2'd3, 7'h7F, '1, 4'hF);
    tick();
    reg_write(7'h7F, 32'hFFFF_FFFF);
    reg_read(7'h7F);
    reg_write(REG_DATA0, 32'hA5A5_5A5A);
    access(CMD_WRITE, REG_DATA1, 32'h1455_0000, 4'hC);
    reg_read(REG_DATA1);
    reg_write(REG_ENABLE, 32'h1);
    reg_write(REG_DATA0, 32'h0000_FFFF);
    reg_write(REG_INT_EN, 32'hFFFF_FFFF);
    reg_write(REG_INT_LVL, 32'h1 << FL_TX_BIT);
    reg_write(REG_GCTRL, (32'h1 << GC_MASTER_BIT) | (32'h1 << GC_ENABLE_BIT));
    reg_write(REG_FMT0, 32'h0000_0001);
    reg_write(REG_DATA0, 32'h0000_8001);
    tick_out_word();
    reg_write(REG_DATA0, 32'h0);
    tick_out_word();
    reg_read(REG_VEC0);
    reg_read(REG_VEC1);
    reg_read(REG_BUF);
    reg_write(REG_FLAGS, 32'hFFFF_FFFF);
    reg_write(REG_GCTRL, (32'h1 << GC_MASTER_BIT) | (32'h1 << GC_ENABLE_BIT) |
                         (32'h1 << GC_LOOPBACK_BIT));
    reg_write(REG_DATA0, 32'h0000_1234);
    tick_out_word();
    reg_write(REG_ENABLE, 32'hFFFF_FFFE);
    reg_read(REG_FMT_LAST);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin sender_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      // One word with every delay field at its maximum runs once, outside the item budget.
      if (ph == 0) word_exchange(1'b1);
      goal = items_done + ITEM_GOAL / 4;
      while (items_done < goal) begin
        if ($urandom_range(99) < 15) noise_item();
        else word_exchange(1'b0);
      end
      settle();
    end

    repeat (8) @(posedge clk_i);
    if (mirror.mismatches == 0 && mirror.replies_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
